FILE: hdl/assert_macros.svh
// Assertion macros for the RTL files; included by the top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CLPS_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication
`define CLPS_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: hdl/clps_pkg.sv
// Package for the character LCD write sequencer: types, codes, constants.
// No dependencies.
package clps_pkg;

   localparam int WAIT_WIDTH = 8;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_WR_CMD = 3'd1;
   localparam logic [2:0] CMD_WR_DAT = 3'd2;
   localparam logic [2:0] CMD_CURSOR = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;
   localparam logic [2:0] CMD_INIT   = 3'd5;

   localparam logic [2:0] REG_POWER_UP   = 3'd0;
   localparam logic [2:0] REG_CMD_SETTLE = 3'd1;
   localparam logic [2:0] REG_INIT_GAP   = 3'd2;
   localparam logic [2:0] REG_CLEAR_WAIT = 3'd3;
   localparam logic [2:0] REG_FUNC_SET   = 3'd4;
   localparam logic [2:0] REG_DISP_CTRL  = 3'd5;

   localparam logic [7:0] BYTE_ENTRY_MODE = 8'h06;
   localparam logic [7:0] BYTE_CLEAR      = 8'h01;
   localparam logic [7:0] BYTE_DDRAM_ADDR = 8'h80;
   localparam logic [7:0] BYTE_LINE1_OFS  = 8'h40;

   localparam logic [2:0] INIT_STEP_NONE  = 3'd0;
   localparam logic [2:0] INIT_STEP_POWER = 3'd1;
   localparam logic [2:0] INIT_STEP_LAST  = 3'd6;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_WRITE = 2'd2,
      OP_INIT  = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      WK_SETTLE = 2'd0,
      WK_ONE    = 2'd1,
      WK_CLEAR  = 2'd2
   } wait_kind_type;

   typedef struct packed {
      op_kind_type   kind;
      logic          sel;
      logic [7:0]    data;
      wait_kind_type wait_kind;
   } op_type;

   typedef struct packed {
      logic [7:0] power_up;
      logic [3:0] cmd_settle;
      logic [5:0] init_gap;
      logic [5:0] clear_wait;
      logic [7:0] func_set;
      logic [7:0] disp_ctrl;
   } cfg_type;

   localparam longint unsigned WAIT_MAX = (64'd1 << WAIT_WIDTH) - 64'd1;

   function automatic logic [WAIT_WIDTH-1:0] sat_wait(input logic [8:0] v);
      if (64'(v) > WAIT_MAX) begin
         return '1;
      end
      return WAIT_WIDTH'(v);
   endfunction

endpackage

FILE: hdl/clps_front.sv
// Front end: accepts request transactions and classifies them into operations.
// Depends on clps_pkg.
module clps_front
   import clps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_byte_value,
   input  logic       req_line,
   input  logic [5:0] req_column,
   output logic       op_valid,
   output op_type     op_data,
   input  logic       op_ready
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   take;
   logic [7:0] cursor_byte;

   assign req_stall = valid_ff && !op_ready;
   assign take      = req_valid && !req_stall;
   assign cursor_byte = BYTE_DDRAM_ADDR + (req_line ? BYTE_LINE1_OFS : 8'h00)
                        + {2'b00, req_column};

   always_comb begin
      op_in.kind      = OP_NONE;
      op_in.sel       = 1'b0;
      op_in.data      = req_byte_value;
      op_in.wait_kind = WK_SETTLE;
      case (req_cmd)
         CMD_TICK: begin
            op_in.kind = OP_TICK;
         end
         CMD_WR_CMD: begin
            op_in.kind = OP_WRITE;
         end
         CMD_WR_DAT: begin
            op_in.kind      = OP_WRITE;
            op_in.sel       = 1'b1;
            op_in.wait_kind = WK_ONE;
         end
         CMD_CURSOR: begin
            op_in.kind = OP_WRITE;
            op_in.data = cursor_byte;
         end
         CMD_CLEAR: begin
            op_in.kind      = OP_WRITE;
            op_in.data      = BYTE_CLEAR;
            op_in.wait_kind = WK_CLEAR;
         end
         CMD_INIT: begin
            op_in.kind = OP_INIT;
         end
         default: begin
            op_in.kind = OP_NONE;
         end
      endcase
   end

   assign valid_in = take ? 1'b1 : (op_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         op_ff <= op_in;
      end
   end

   assign op_valid = valid_ff;
   assign op_data  = op_ff;

endmodule

FILE: hdl/clps_fifo.sv
// Short operation queue between front end and sequencer back end.
// Depends on clps_pkg.
module clps_fifo
   import clps_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   output logic   not_full,
   input  logic   pop,
   output logic   not_empty,
   output op_type pop_data
);

   op_type                 mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign not_full  = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/clps_back.sv
// Back end: bus phase sequencer, init sequence and result register.
// Depends on clps_pkg.
module clps_back
   import clps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       op_valid,
   input  op_type     op_data,
   output logic       op_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_rs_pin,
   output logic       rsp_rw_pin,
   output logic       rsp_en_pin,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_busy_res,
   output logic       rsp_rejected
);

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SETUP  = 5'b00010,
      PH_DATA   = 5'b00100,
      PH_STROBE = 5'b01000,
      PH_SETTLE = 5'b10000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0]            held_byte_ff, held_byte_in;
   logic                  held_sel_ff, held_sel_in;
   logic [2:0]            step_ff, step_in;
   logic [7:0]            bus_ff, bus_in;
   logic                  en_ff, en_in;
   logic                  rs_ff, rs_in;
   logic                  rej;

   logic                  out_valid_ff;
   logic                  out_rs_ff, out_en_ff, out_busy_ff, out_rej_ff;
   logic [7:0]            out_bus_ff;

   logic [2:0]            init_k;
   logic [7:0]            init_byte;
   logic [8:0]            init_wait;
   logic [8:0]            req_wait;

   assign op_pop = op_valid && (!out_valid_ff || !rsp_stall);

   assign init_k = step_ff - 3'd1;

   always_comb begin
      init_wait = {5'b0, cfg.cmd_settle} + {3'b0, cfg.init_gap};
      if (init_k < 3'd3) begin
         init_byte = cfg.func_set;
      end else if (init_k == 3'd3) begin
         init_byte = cfg.disp_ctrl;
      end else if (init_k == 3'd4) begin
         init_byte = BYTE_ENTRY_MODE;
      end else begin
         init_byte = BYTE_CLEAR;
         init_wait = {5'b0, cfg.cmd_settle} + {3'b0, cfg.clear_wait};
      end
   end

   always_comb begin
      case (op_data.wait_kind)
         WK_SETTLE: req_wait = {5'b0, cfg.cmd_settle};
         WK_ONE:    req_wait = 9'd1;
         WK_CLEAR:  req_wait = {5'b0, cfg.cmd_settle} + {3'b0, cfg.clear_wait};
         default:   req_wait = {5'b0, cfg.cmd_settle};
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      held_byte_in = held_byte_ff;
      held_sel_in  = held_sel_ff;
      step_in      = step_ff;
      bus_in       = bus_ff;
      en_in        = en_ff;
      rs_in        = rs_ff;
      rej          = 1'b0;
      case (op_data.kind)
         OP_TICK: begin
            case (phase_ff)
               PH_SETUP: begin
                  bus_in   = held_byte_ff;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  en_in    = 1'b1;
                  phase_in = PH_STROBE;
               end
               PH_STROBE: begin
                  en_in    = 1'b0;
                  phase_in = PH_SETTLE;
               end
               PH_SETTLE: begin
                  if (wait_ff > WAIT_WIDTH'(1)) begin
                     wait_in = wait_ff - 1'b1;
                  end else if (step_ff >= INIT_STEP_POWER && step_ff <= INIT_STEP_LAST) begin
                     step_in      = step_ff + 3'd1;
                     held_sel_in  = 1'b0;
                     held_byte_in = init_byte;
                     rs_in        = 1'b0;
                     en_in        = 1'b0;
                     wait_in      = sat_wait(init_wait);
                     phase_in     = PH_SETUP;
                  end else begin
                     wait_in  = '0;
                     step_in  = INIT_STEP_NONE;
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         OP_WRITE: begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               held_sel_in  = op_data.sel;
               held_byte_in = op_data.data;
               rs_in        = op_data.sel;
               en_in        = 1'b0;
               wait_in      = sat_wait(req_wait);
               phase_in     = PH_SETUP;
            end
         end
         OP_INIT: begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               step_in  = INIT_STEP_POWER;
               wait_in  = sat_wait({1'b0, cfg.power_up});
               phase_in = PH_SETTLE;
            end
         end
         default: begin
            rej = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= '0;
         held_byte_ff <= '0;
         held_sel_ff  <= 1'b0;
         step_ff      <= INIT_STEP_NONE;
         bus_ff       <= '0;
         en_ff        <= 1'b0;
         rs_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (op_pop) begin
            phase_ff     <= phase_in;
            wait_ff      <= wait_in;
            held_byte_ff <= held_byte_in;
            held_sel_ff  <= held_sel_in;
            step_ff      <= step_in;
            bus_ff       <= bus_in;
            en_ff        <= en_in;
            rs_ff        <= rs_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (op_pop) begin
         out_rs_ff   <= rs_in;
         out_en_ff   <= en_in;
         out_bus_ff  <= bus_in;
         out_busy_ff <= phase_in != PH_IDLE;
         out_rej_ff  <= rej;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_rs_pin   = out_rs_ff;
   assign rsp_rw_pin   = 1'b0;
   assign rsp_en_pin   = out_en_ff;
   assign rsp_bus_byte = out_bus_ff;
   assign rsp_busy_res = out_busy_ff;
   assign rsp_rejected = out_rej_ff;

endmodule

FILE: hdl/char_lcd_parallel_write_sequencer.sv
// Character LCD 8-bit parallel write sequencer, top level.
// Path from request transaction to result valid: front reg, queue, result reg.
// Throughput: one transaction per cycle while neither rsp_stall nor a full queue holds the flow.
// Reset: synchronous; sequencer idle, result valid low, queue empty, config registers to defaults.
// Depends on clps_pkg, clps_front, clps_fifo, clps_back, assert_macros.svh.
`include "assert_macros.svh"
module char_lcd_parallel_write_sequencer
   import clps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_byte_value,
   input  logic       req_line,
   input  logic [5:0] req_column,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_rs_pin,
   output logic       rsp_rw_pin,
   output logic       rsp_en_pin,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_busy_res,
   output logic       rsp_rejected,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    front_valid;
   op_type  front_op;
   logic    fifo_not_full;
   logic    fifo_not_empty;
   op_type  fifo_op;
   logic    back_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_up   <= 8'd50;
         cfg_ff.cmd_settle <= 4'd2;
         cfg_ff.init_gap   <= 6'd5;
         cfg_ff.clear_wait <= 6'd10;
         cfg_ff.func_set   <= 8'h38;
         cfg_ff.disp_ctrl  <= 8'h0C;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_POWER_UP:   cfg_ff.power_up   <= csr_wdata;
            REG_CMD_SETTLE: cfg_ff.cmd_settle <= csr_wdata[3:0];
            REG_INIT_GAP:   cfg_ff.init_gap   <= csr_wdata[5:0];
            REG_CLEAR_WAIT: cfg_ff.clear_wait <= csr_wdata[5:0];
            REG_FUNC_SET:   cfg_ff.func_set   <= csr_wdata;
            REG_DISP_CTRL:  cfg_ff.disp_ctrl  <= csr_wdata;
            default: ;
         endcase
      end
   end

   clps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_byte_value (req_byte_value),
      .req_line       (req_line),
      .req_column     (req_column),
      .op_valid       (front_valid),
      .op_data        (front_op),
      .op_ready       (fifo_not_full)
   );

   clps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_op),
      .not_full  (fifo_not_full),
      .pop       (back_pop),
      .not_empty (fifo_not_empty),
      .pop_data  (fifo_op)
   );

   clps_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .op_valid     (fifo_not_empty),
      .op_data      (fifo_op),
      .op_pop       (back_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rs_pin   (rsp_rs_pin),
      .rsp_rw_pin   (rsp_rw_pin),
      .rsp_en_pin   (rsp_en_pin),
      .rsp_bus_byte (rsp_bus_byte),
      .rsp_busy_res (rsp_busy_res),
      .rsp_rejected (rsp_rejected)
   );

   `CLPS_ASSERT_IMP(a_rej_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res)
   `CLPS_ASSERT_IMP(a_en_busy, clock, reset, rsp_valid && rsp_en_pin, rsp_busy_res)
   `CLPS_ASSERT_IMP(a_pop_has_data, clock, reset, back_pop, fifo_not_empty)
   `CLPS_ASSERT_NXT(a_stall_full, clock, reset, req_stall, front_valid)

endmodule
